// File: hdl/wfcp_pkg.sv
`timescale 1ns / 1ps

package wfcp_pkg;

  localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
  localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
  localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
  localparam logic [31:0] TAG_DATA = 32'h6461_7461;

  localparam logic [31:0] FMT_MIN_LEN = 32'd16;
  localparam logic [31:0] HEADER_LEN  = 32'd12;
  localparam logic [31:0] HDR_LEN     = 32'd8;
  localparam logic [31:0] RIFF_LAST   = 32'd3;
  localparam logic [31:0] WAVE_LAST   = 32'd11;
  localparam logic [31:0] ID_LEN      = 32'd4;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_CHUNK_HDR,
    PH_BODY,
    PH_PAD,
    PH_IDLE
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK,
    ST_BAD_HEADER,
    ST_NO_FORMAT,
    ST_NO_DATA
  } status_t;

  typedef enum logic {
    KIND_PAYLOAD,
    KIND_SUMMARY
  } kind_t;

  typedef struct packed {
    kind_t        kind;
    logic [7:0]   payload_byte;
    logic         chunk_start;
    logic [127:0] format;
    status_t      status;
    logic         run_end;
  } result_t;

  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } result_push_t;

endpackage

// File: hdl/wave_file_chunk_parser.sv
`timescale 1ns / 1ps

// Parses a RIFF wave file streamed in one byte per item, with tlast on the last
// byte, and takes one byte in every clock cycle while the four-entry result
// queue has room for two items; each data-chunk body byte leaves as a payload
// item and the last byte of the file adds a summary item with the format fields
// and a status, after which the parser is ready for the next file.
module wave_file_chunk_parser (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [7:0]   s_tdata,   // byte_value
  input  logic         s_tlast,   // is_final
  output logic         m_tvalid,
  input  logic         m_tready,
  // payload_byte, chunk_start, format_code, channel_count, sample_rate,
  // byte_rate, frame_align, sample_bits, status, zero fill
  output logic [143:0] m_tdata,
  output logic         m_tuser,   // kind
  output logic         m_tlast    // run_end
);

  wfcp_pkg::result_push_t push;
  wfcp_pkg::result_t      head;
  logic                   room;

  assign s_tready = room;

  wfcp_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .accept     (s_tvalid && room),
    .byte_value (s_tdata),
    .is_final   (s_tlast),
    .push       (push)
  );

  wfcp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .room       (room),
    .head_valid (m_tvalid),
    .head       (head),
    .pop        (m_tready)
  );

  assign m_tdata = {5'd0, head.status, head.format, head.chunk_start, head.payload_byte};
  assign m_tuser = head.kind;
  assign m_tlast = head.run_end;

endmodule

// File: hdl/wfcp_parser.sv
`timescale 1ns / 1ps

module wfcp_parser (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  accept,
  input  logic [7:0]            byte_value,
  input  logic                  is_final,
  output wfcp_pkg::result_push_t push
);

  wfcp_pkg::phase_t phase, phase_next;
  logic [31:0]  position_count, position_count_next;
  logic [31:0]  tag_shift, tag_shift_next;
  logic [31:0]  chunk_length, chunk_length_next;
  logic         header_bad, header_bad_next;
  logic [127:0] pending_format, pending_format_next;
  logic [127:0] committed_format, committed_format_next;
  logic [1:0]   found_flags, found_flags_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= wfcp_pkg::PH_HEADER;
      position_count   <= '0;
      tag_shift        <= '0;
      chunk_length     <= '0;
      header_bad       <= 1'b0;
      pending_format   <= '0;
      committed_format <= '0;
      found_flags      <= '0;
    end else if (accept) begin
      phase            <= phase_next;
      position_count   <= position_count_next;
      tag_shift        <= tag_shift_next;
      chunk_length     <= chunk_length_next;
      header_bad       <= header_bad_next;
      pending_format   <= pending_format_next;
      committed_format <= committed_format_next;
      found_flags      <= found_flags_next;
    end
  end

  always_comb begin
    logic [31:0]          pos_inc;
    logic                 complete;
    logic                 pay_valid;
    wfcp_pkg::result_t    pay;
    wfcp_pkg::result_t    sum;
    wfcp_pkg::status_t    st;

    phase_next            = phase;
    position_count_next   = position_count;
    tag_shift_next        = tag_shift;
    chunk_length_next     = chunk_length;
    header_bad_next       = header_bad;
    pending_format_next   = pending_format;
    committed_format_next = committed_format;
    found_flags_next      = found_flags;
    pos_inc               = position_count + 32'd1;
    complete              = 1'b0;
    pay_valid             = 1'b0;
    pay                   = '0;
    sum                   = '0;
    st                    = wfcp_pkg::ST_OK;

    case (phase)
      wfcp_pkg::PH_HEADER: begin
        tag_shift_next = {tag_shift[23:0], byte_value};
        if (position_count == wfcp_pkg::RIFF_LAST && tag_shift_next != wfcp_pkg::TAG_RIFF) begin
          header_bad_next = 1'b1;
        end
        if (position_count == wfcp_pkg::WAVE_LAST && tag_shift_next != wfcp_pkg::TAG_WAVE) begin
          header_bad_next = 1'b1;
        end
        position_count_next = pos_inc;
        if (header_bad_next) begin
          phase_next = wfcp_pkg::PH_IDLE;
        end else if (pos_inc == wfcp_pkg::HEADER_LEN) begin
          phase_next          = wfcp_pkg::PH_CHUNK_HDR;
          position_count_next = '0;
        end
      end
      wfcp_pkg::PH_CHUNK_HDR: begin
        if (position_count < wfcp_pkg::ID_LEN) begin
          tag_shift_next = {tag_shift[23:0], byte_value};
        end else begin
          chunk_length_next = {byte_value, chunk_length[31:8]};
        end
        position_count_next = pos_inc;
        if (pos_inc == wfcp_pkg::HDR_LEN) begin
          position_count_next = '0;
          if (chunk_length_next == '0) begin
            complete = 1'b1;
          end else begin
            phase_next = wfcp_pkg::PH_BODY;
          end
        end
      end
      wfcp_pkg::PH_BODY: begin
        if (tag_shift == wfcp_pkg::TAG_FMT && position_count < wfcp_pkg::FMT_MIN_LEN) begin
          pending_format_next[{position_count[3:0], 3'b000} +: 8] = byte_value;
        end
        if (tag_shift == wfcp_pkg::TAG_DATA) begin
          pay_valid         = 1'b1;
          pay.kind          = wfcp_pkg::KIND_PAYLOAD;
          pay.payload_byte  = byte_value;
          pay.chunk_start   = (position_count == '0);
        end
        position_count_next = pos_inc;
        if (pos_inc == chunk_length) begin
          complete            = 1'b1;
          position_count_next = '0;
          phase_next = chunk_length[0] ? wfcp_pkg::PH_PAD : wfcp_pkg::PH_CHUNK_HDR;
        end
      end
      wfcp_pkg::PH_PAD: begin
        phase_next          = wfcp_pkg::PH_CHUNK_HDR;
        position_count_next = '0;
      end
      default: begin
      end
    endcase

    if (complete) begin
      if (tag_shift_next == wfcp_pkg::TAG_FMT && chunk_length_next >= wfcp_pkg::FMT_MIN_LEN) begin
        committed_format_next = pending_format_next;
        found_flags_next[0]   = 1'b1;
      end else if (tag_shift_next == wfcp_pkg::TAG_DATA) begin
        found_flags_next[1] = 1'b1;
      end
    end

    if (header_bad_next || phase_next == wfcp_pkg::PH_HEADER) begin
      st = wfcp_pkg::ST_BAD_HEADER;
    end else if (!found_flags_next[0]) begin
      st = wfcp_pkg::ST_NO_FORMAT;
    end else if (!found_flags_next[1]) begin
      st = wfcp_pkg::ST_NO_DATA;
    end else begin
      st = wfcp_pkg::ST_OK;
    end
    sum.kind    = wfcp_pkg::KIND_SUMMARY;
    sum.status  = st;
    sum.run_end = 1'b1;
    if (st != wfcp_pkg::ST_BAD_HEADER) begin
      sum.format = committed_format_next;
    end

    push = '0;
    if (pay_valid && is_final) begin
      push.count  = 2'd2;
      push.first  = pay;
      push.second = sum;
    end else if (pay_valid) begin
      pay.run_end = 1'b1;
      push.count  = 2'd1;
      push.first  = pay;
    end else if (is_final) begin
      push.count = 2'd1;
      push.first = sum;
    end
    if (!accept) begin
      push.count = 2'd0;
    end

    if (is_final) begin
      phase_next            = wfcp_pkg::PH_HEADER;
      position_count_next   = '0;
      tag_shift_next        = '0;
      chunk_length_next     = '0;
      header_bad_next       = 1'b0;
      pending_format_next   = '0;
      committed_format_next = '0;
      found_flags_next      = '0;
    end
  end

endmodule

// File: hdl/wfcp_queue.sv
`timescale 1ns / 1ps

module wfcp_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  wfcp_pkg::result_push_t push,
  output logic                   room,
  output logic                   head_valid,
  output wfcp_pkg::result_t      head,
  input  logic                   pop
);

  wfcp_pkg::result_t mem [wfcp_pkg::QUEUE_DEPTH];
  logic [wfcp_pkg::QUEUE_AW-1:0] wr_ptr;
  logic [wfcp_pkg::QUEUE_AW-1:0] rd_ptr;
  logic [wfcp_pkg::QUEUE_AW:0]   count;
  logic                          do_pop;

  assign head_valid = (count != '0);
  assign head       = mem[rd_ptr];
  assign do_pop     = pop && head_valid;
  assign room       = (count <= (wfcp_pkg::QUEUE_AW + 1)'(wfcp_pkg::QUEUE_DEPTH - 2));

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem[wr_ptr] <= push.first;
    end
    if (push.count == 2'd2) begin
      mem[wr_ptr + wfcp_pkg::QUEUE_AW'(1)] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + wfcp_pkg::QUEUE_AW'(push.count);
      if (do_pop) begin
        rd_ptr <= rd_ptr + wfcp_pkg::QUEUE_AW'(1);
      end
      count <= count + (wfcp_pkg::QUEUE_AW + 1)'(push.count)
             - (wfcp_pkg::QUEUE_AW + 1)'(do_pop);
    end
  end

endmodule

// File: sim/wave_file_chunk_parser_test.sv
`timescale 1ns / 1ps

module wave_file_chunk_parser_test;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 16;

  typedef struct {
    wfcp_pkg::kind_t   kind;
    logic [7:0]        data_byte;
    logic              first_of_chunk;
    logic [15:0]       fmt_code;
    logic [15:0]       chans;
    logic [31:0]       rate;
    logic [31:0]       brate;
    logic [15:0]       align;
    logic [15:0]       bits;
    wfcp_pkg::status_t status;
    logic              last;
  } wave_result_t;

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [7:0]   s_tdata;
  logic         s_tlast;
  logic         m_tvalid;
  logic         m_tready;
  logic [143:0] m_tdata;
  logic         m_tuser;
  logic         m_tlast;

  wave_result_t predicted_results[$];
  logic [7:0]   wave_bytes[$];
  int           mismatch_count = 0;
  int           items_sent = 0;
  int           cycle_count = 0;
  bit           steady_flow = 1'b0;

  wfcp_pkg::phase_t phase;
  logic [31:0]  byte_pos;
  logic [31:0]  tag_word;
  logic [31:0]  seg_len;
  logic         header_bad;
  logic [127:0] format_staged;
  logic [127:0] format_kept;
  logic [1:0]   found;

  wave_file_chunk_parser dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  task automatic add_byte(input logic [7:0] value);
    wave_bytes = {wave_bytes, value};
  endtask

  task automatic add_result(input wave_result_t r);
    predicted_results = {predicted_results, r};
  endtask

  task automatic clear_parser_state();
    phase = wfcp_pkg::PH_HEADER;
    byte_pos = '0;
    tag_word = '0;
    seg_len = '0;
    header_bad = 1'b0;
    format_staged = '0;
    format_kept = '0;
    found = '0;
  endtask

  task automatic close_chunk();
    if (tag_word == wfcp_pkg::TAG_FMT && seg_len >= wfcp_pkg::FMT_MIN_LEN) begin
      format_kept = format_staged;
      found[0] = 1'b1;
    end else if (tag_word == wfcp_pkg::TAG_DATA) begin
      found[1] = 1'b1;
    end
  endtask

  task automatic parse_byte(input logic [7:0] b, input logic fin);
    wave_result_t r;
    wfcp_pkg::status_t st;
    r.kind = wfcp_pkg::KIND_PAYLOAD;
    r.data_byte = '0;
    r.first_of_chunk = 1'b0;
    r.fmt_code = '0;
    r.chans = '0;
    r.rate = '0;
    r.brate = '0;
    r.align = '0;
    r.bits = '0;
    r.status = wfcp_pkg::ST_OK;
    r.last = 1'b0;
    case (phase)
      wfcp_pkg::PH_HEADER: begin
        tag_word = {tag_word[23:0], b};
        if (byte_pos == wfcp_pkg::RIFF_LAST && tag_word != wfcp_pkg::TAG_RIFF)
          header_bad = 1'b1;
        if (byte_pos == wfcp_pkg::WAVE_LAST && tag_word != wfcp_pkg::TAG_WAVE)
          header_bad = 1'b1;
        byte_pos = byte_pos + 32'd1;
        if (header_bad) begin
          phase = wfcp_pkg::PH_IDLE;
        end else if (byte_pos == wfcp_pkg::HEADER_LEN) begin
          phase = wfcp_pkg::PH_CHUNK_HDR;
          byte_pos = '0;
        end
      end
      wfcp_pkg::PH_CHUNK_HDR: begin
        if (byte_pos < wfcp_pkg::ID_LEN) tag_word = {tag_word[23:0], b};
        else seg_len = {b, seg_len[31:8]};
        byte_pos = byte_pos + 32'd1;
        if (byte_pos == wfcp_pkg::HDR_LEN) begin
          byte_pos = '0;
          if (seg_len == '0) close_chunk();
          else phase = wfcp_pkg::PH_BODY;
        end
      end
      wfcp_pkg::PH_BODY: begin
        if (tag_word == wfcp_pkg::TAG_FMT && byte_pos < wfcp_pkg::FMT_MIN_LEN)
          format_staged[{byte_pos[3:0], 3'b000} +: 8] = b;
        if (tag_word == wfcp_pkg::TAG_DATA) begin
          r.data_byte = b;
          r.first_of_chunk = (byte_pos == '0);
          r.last = !fin;
          add_result(r);
        end
        byte_pos = byte_pos + 32'd1;
        if (byte_pos == seg_len) begin
          close_chunk();
          byte_pos = '0;
          phase = seg_len[0] ? wfcp_pkg::PH_PAD : wfcp_pkg::PH_CHUNK_HDR;
        end
      end
      wfcp_pkg::PH_PAD: begin
        phase = wfcp_pkg::PH_CHUNK_HDR;
        byte_pos = '0;
      end
      default: ;
    endcase
    if (fin) begin
      if (header_bad || phase == wfcp_pkg::PH_HEADER) st = wfcp_pkg::ST_BAD_HEADER;
      else if (!found[0]) st = wfcp_pkg::ST_NO_FORMAT;
      else if (!found[1]) st = wfcp_pkg::ST_NO_DATA;
      else st = wfcp_pkg::ST_OK;
      r.kind = wfcp_pkg::KIND_SUMMARY;
      r.data_byte = '0;
      r.first_of_chunk = 1'b0;
      r.status = st;
      r.last = 1'b1;
      if (st != wfcp_pkg::ST_BAD_HEADER) begin
        r.fmt_code = format_kept[15:0];
        r.chans = format_kept[31:16];
        r.rate = format_kept[63:32];
        r.brate = format_kept[95:64];
        r.align = format_kept[111:96];
        r.bits = format_kept[127:112];
      end
      add_result(r);
      clear_parser_state();
    end
  endtask

  function automatic void check_field(input string name, input logic [31:0] exp_val,
                                      input logic [31:0] act_val);
    if (exp_val !== act_val) begin
      $error("%s expected %0h got %0h", name, exp_val, act_val);
      mismatch_count++;
    end
  endfunction

  task automatic check_result();
    wave_result_t exp_r;
    if (predicted_results.size() == 0) begin
      $error("unexpected result item, tdata %0h", m_tdata);
      mismatch_count++;
      return;
    end
    exp_r = predicted_results.pop_front();
    check_field("kind", 32'(exp_r.kind), 32'(m_tuser));
    check_field("payload_byte", 32'(exp_r.data_byte), 32'(m_tdata[7:0]));
    check_field("chunk_start", 32'(exp_r.first_of_chunk), 32'(m_tdata[8]));
    check_field("format_code", 32'(exp_r.fmt_code), 32'(m_tdata[24:9]));
    check_field("channel_count", 32'(exp_r.chans), 32'(m_tdata[40:25]));
    check_field("sample_rate", exp_r.rate, m_tdata[72:41]);
    check_field("byte_rate", exp_r.brate, m_tdata[104:73]);
    check_field("frame_align", 32'(exp_r.align), 32'(m_tdata[120:105]));
    check_field("sample_bits", 32'(exp_r.bits), 32'(m_tdata[136:121]));
    check_field("status", 32'(exp_r.status), 32'(m_tdata[138:137]));
    check_field("run_end", 32'(exp_r.last), 32'(m_tlast));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_parser_state();
    end else begin
      if (s_tvalid && s_tready) parse_byte(s_tdata, s_tlast);
      if (m_tvalid && m_tready) check_result();
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL wave_file_chunk_parser");
      $finish;
    end
  end

  initial begin
    int stall;
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!steady_flow && $urandom_range(0, 4) == 0) begin
        stall = $urandom_range(1, 8);
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
    end
  end

  task automatic send_byte(input logic [7:0] value, input logic fin);
    int gap;
    if (!steady_flow && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 8);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= value;
    s_tlast <= fin;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_file();
    foreach (wave_bytes[i]) send_byte(wave_bytes[i], i == wave_bytes.size() - 1);
  endtask

  task automatic push_tag(input logic [31:0] id);
    for (int i = 3; i >= 0; i--) add_byte(id[8 * i +: 8]);
  endtask

  task automatic push_word_le(input logic [31:0] word);
    for (int i = 0; i < 4; i++) add_byte(word[8 * i +: 8]);
  endtask

  // A damaged file may carry a broken tag, a chunk that runs past the end
  // of the file, or be cut short at any point.
  task automatic build_file(input bit damage);
    int n_chunks;
    int pick;
    int cut;
    logic [31:0] id;
    logic [31:0] size;
    logic [31:0] body;
    logic [31:0] riff_id;
    logic [31:0] wave_id;
    riff_id = wfcp_pkg::TAG_RIFF;
    wave_id = wfcp_pkg::TAG_WAVE;
    if (damage && $urandom_range(0, 5) == 0) riff_id ^= 32'd1 << $urandom_range(0, 31);
    if (damage && $urandom_range(0, 5) == 0) wave_id ^= 32'd1 << $urandom_range(0, 31);
    wave_bytes.delete();
    push_tag(riff_id);
    push_word_le($urandom());
    push_tag(wave_id);
    n_chunks = $urandom_range(0, 4);
    for (int c = 0; c < n_chunks; c++) begin
      pick = $urandom_range(0, 9);
      if (pick < 3) begin
        id = wfcp_pkg::TAG_FMT;
        case ($urandom_range(0, 5))
          0: size = 32'd14;
          1: size = 32'd18;
          2: size = 32'd0;
          default: size = 32'd16;
        endcase
      end else if (pick < 7) begin
        id = wfcp_pkg::TAG_DATA;
        size = $urandom_range(0, 10);
      end else begin
        id = $urandom();
        size = $urandom_range(0, 5);
      end
      if (damage && $urandom_range(0, 7) == 0) size = $urandom() | 32'h0000_0100;
      push_tag(id);
      push_word_le(size);
      body = (size > 24) ? 32'd24 : size;
      for (int i = 0; i < body; i++) add_byte(8'($urandom_range(0, 255)));
      if (size > 24) break;
      if (size[0] && !(damage && c == n_chunks - 1 && $urandom_range(0, 1) == 0))
        add_byte(8'($urandom_range(0, 255)));
    end
    if (damage && $urandom_range(0, 2) == 0) begin
      cut = $urandom_range(1, wave_bytes.size());
      while (wave_bytes.size() > cut) void'(wave_bytes.pop_back());
    end
  endtask

  task automatic test_short_files();
    send_byte(8'h00, 1'b1);
    send_byte(8'h52, 1'b0);
    send_byte(8'h49, 1'b0);
    send_byte(8'h46, 1'b1);
    wave_bytes.delete();
    push_tag(wfcp_pkg::TAG_RIFF);
    push_word_le(32'hFFFF_FFFF);
    push_tag(wfcp_pkg::TAG_WAVE);
    send_file();
  endtask

  task automatic test_bad_tags();
    wave_bytes.delete();
    push_tag(wfcp_pkg::TAG_RIFF ^ 32'h1);
    add_byte(8'hFF);
    add_byte(8'h00);
    send_file();
  endtask

  task automatic test_chunk_walk();
    while (items_sent < 350) begin
      build_file(1'b0);
      send_file();
    end
  endtask

  task automatic test_damaged_files();
    while (items_sent < 600) begin
      build_file(1'b1);
      send_file();
    end
  endtask

  // Random bytes after a good header drive the chunk walk with arbitrary
  // ids and sizes; every other file holds only random bytes, with no header.
  task automatic test_noise();
    int n;
    for (int f = 0; f < 4; f++) begin
      wave_bytes.delete();
      if (f % 2 == 0) begin
        push_tag(wfcp_pkg::TAG_RIFF);
        push_word_le($urandom());
        push_tag(wfcp_pkg::TAG_WAVE);
      end
      n = $urandom_range(4, 30);
      for (int i = 0; i < n; i++) add_byte(8'($urandom_range(0, 255)));
      send_file();
    end
  endtask

  task automatic test_back_to_back();
    steady_flow = 1'b1;
    while (items_sent < 850) begin
      build_file($urandom_range(0, 1));
      send_file();
    end
  endtask

  initial begin
    rst <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata <= '0;
    s_tlast <= 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_short_files();
    test_bad_tags();
    test_chunk_walk();
    test_damaged_files();
    test_noise();
    test_back_to_back();
    s_tvalid <= 1'b0;
    while (predicted_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASS wave_file_chunk_parser");
    end else begin
      $display("FAIL wave_file_chunk_parser");
    end
    $finish;
  end

endmodule

// File: files.f
hdl/wfcp_pkg.sv
hdl/wfcp_parser.sv
hdl/wfcp_queue.sv
hdl/wave_file_chunk_parser.sv
sim/wave_file_chunk_parser_test.sv
